[src/prw_pkg.sv]
`timescale 1ns / 1ps
package prw_pkg;
  localparam int unsigned CountWidth = 11;
  localparam int unsigned WeightWidth = 32;
  localparam int unsigned PoseWidth = 32;
  localparam int unsigned RandWidth = 32;
  localparam int unsigned BetaWidth = 34;
  localparam int unsigned PickWidth = 10;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_DRAW  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_READ,
    ST_WAIT,
    ST_CMP,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [WeightWidth-1:0] weight;
    logic [PoseWidth-1:0]   pos_x;
    logic [PoseWidth-1:0]   pos_y;
    logic [PoseWidth-1:0]   heading;
    logic [RandWidth-1:0]   rnd;
  } cmd_t;
endpackage

[src/prw_if.sv]
`timescale 1ns / 1ps
interface prw_in_if;
  import prw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [WeightWidth-1:0] weight_in;
  logic signed [PoseWidth-1:0] pos_x_in;
  logic signed [PoseWidth-1:0] pos_y_in;
  logic signed [PoseWidth-1:0] heading_in;
  logic [RandWidth-1:0]   random_fraction;
  modport source (output valid, opcode, weight_in, pos_x_in, pos_y_in, heading_in,
                  random_fraction, input ready);
  modport sink (input valid, opcode, weight_in, pos_x_in, pos_y_in, heading_in,
                random_fraction, output ready);
endinterface

interface prw_out_if;
  import prw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PickWidth-1:0]   picked_index;
  logic signed [PoseWidth-1:0] pos_x_out;
  logic signed [PoseWidth-1:0] pos_y_out;
  logic signed [PoseWidth-1:0] heading_out;
  logic [WeightWidth-1:0] weight_out;
  modport source (output valid, picked_index, pos_x_out, pos_y_out, heading_out,
                  weight_out, input ready);
  modport sink (input valid, picked_index, pos_x_out, pos_y_out, heading_out,
                weight_out, output ready);
endinterface

interface prw_cfg_if;
  import prw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[src/prw_front.sv]
`timescale 1ns / 1ps
module prw_front (
  input  logic          clk,
  input  logic          rst,
  prw_in_if.sink        in_ch,
  output prw_pkg::cmd_t q_data,
  output logic          q_valid,
  input  logic          q_ready
);
  import prw_pkg::*;

  // Two-entry queue; opcode 3 is dropped at the door.
  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       incoming;

  assign in_ch.ready = (fill != 2'd2);
  assign incoming = '{opcode: opcode_t'(in_ch.opcode), weight: in_ch.weight_in,
                      pos_x: in_ch.pos_x_in, pos_y: in_ch.pos_y_in,
                      heading: in_ch.heading_in, rnd: in_ch.random_fraction};
  assign push = in_ch.valid && in_ch.ready && (in_ch.opcode != OP_NONE);
  assign pop = q_valid && q_ready;
  assign q_valid = (fill != 2'd0);
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd0 |-> !pop) else $error("pop from empty queue");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + 2'd1) else $error("fill did not advance");
`endif
endmodule

[src/prw_back.sv]
`timescale 1ns / 1ps
module prw_back #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  prw_pkg::cmd_t                   q_data,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  logic [prw_pkg::CountWidth-1:0]  count_reg,
  prw_out_if.source                       out_ch
);
  import prw_pkg::*;

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned NW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned LW = NW + 2;
  localparam logic [BetaWidth-1:0] BetaMax = '1;

  logic [WeightWidth-1:0] wmem [SLOT_COUNT];
  logic [3*PoseWidth-1:0] pmem [SLOT_COUNT];

  back_state_t state, state_next;
  cmd_t        cmd;
  logic [NW-1:0] n;
  logic [NW-1:0] load_pos;
  logic [WeightWidth-1:0] largest;
  logic [BetaWidth-1:0]   beta;
  logic [AW-1:0]          wheel;
  logic [LW-1:0]          steps;
  logic [63:0]            prod;
  logic [BetaWidth:0]     beta_sum;
  logic [WeightWidth-1:0] rd_w;
  logic [3*PoseWidth-1:0] rd_p;
  logic                   out_valid;
  logic [PickWidth-1:0]   o_idx;
  logic [WeightWidth-1:0] o_w;
  logic [3*PoseWidth-1:0] o_p;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          wheel_inc;
  logic                   take;
  logic                   walk_go;
  logic [NW+RandWidth-1:0] start_prod;

  // Effective count: register clamped to [1, SLOT_COUNT].
  always_comb begin
    if (count_reg == '0) n = NW'(1);
    else if ({{(32-CountWidth){1'b0}}, count_reg} > SLOT_COUNT) n = NW'(SLOT_COUNT);
    else n = NW'(count_reg);
  end

  assign wr_addr = (load_pos >= n) ? '0 : load_pos[AW-1:0];
  assign wheel_inc = (NW'(wheel) + NW'(1) >= n) ? '0 : wheel + 1'b1;
  assign take = q_valid && q_ready;
  assign q_ready = (state == ST_IDLE);
  assign start_prod = q_data.rnd * n;
  assign walk_go = (steps < LW'({n, 2'b00})) && ({2'b00, rd_w} < beta);

  always_ff @(posedge clk) begin
    if (take && q_data.opcode == OP_LOAD) begin
      wmem[wr_addr] <= q_data.weight;
      pmem[wr_addr] <= {q_data.pos_x, q_data.pos_y, q_data.heading};
    end
  end

  always_ff @(posedge clk) begin
    rd_w <= wmem[wheel];
    rd_p <= pmem[wheel];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (take && q_data.opcode == OP_DRAW) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_READ;
      ST_READ: state_next = ST_WAIT;
      ST_WAIT: state_next = ST_CMP;
      ST_CMP:  state_next = walk_go ? ST_READ : ST_EMIT;
      ST_EMIT: if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign beta_sum = {1'b0, beta} + {2'b00, prod[63:31]};

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) cmd <= q_data;
    if (state == ST_MUL) prod <= cmd.rnd * largest;
    if (state == ST_EMIT && (!out_valid || out_ch.ready)) begin
      o_idx <= PickWidth'(wheel);
      o_w <= rd_w;
      o_p <= rd_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      load_pos <= '0;
      largest <= '0;
      beta <= '0;
      wheel <= '0;
      steps <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (take) begin
        unique case (q_data.opcode)
          OP_LOAD: begin
            if (wr_addr == '0 || q_data.weight > largest) largest <= q_data.weight;
            load_pos <= (NW'(wr_addr) + NW'(1) >= n) ? '0 : NW'(wr_addr) + NW'(1);
          end
          OP_START: begin
            wheel <= AW'(start_prod[NW+RandWidth-1:RandWidth]);
            beta <= '0;
            load_pos <= '0;
          end
          default: ;
        endcase
      end
      if (state == ST_ADD) begin
        beta <= beta_sum[BetaWidth] ? BetaMax : beta_sum[BetaWidth-1:0];
        steps <= '0;
        if (NW'(wheel) >= n) wheel <= '0;
      end
      if (state == ST_CMP && walk_go) begin
        beta <= beta - {2'b00, rd_w};
        wheel <= wheel_inc;
        steps <= steps + 1'b1;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.picked_index = o_idx;
  assign out_ch.pos_x_out = o_p[3*PoseWidth-1:2*PoseWidth];
  assign out_ch.pos_y_out = o_p[2*PoseWidth-1:PoseWidth];
  assign out_ch.heading_out = o_p[PoseWidth-1:0];
  assign out_ch.weight_out = o_w;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> state == ST_IDLE) else $error("accepted while busy");
  a_wheel_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> NW'(wheel) < n) else $error("wheel out of range");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && state_next == ST_IDLE |=> out_valid)
    else $error("result lost");
`endif
endmodule

[src/particle_resampling_wheel_top.sv]
`timescale 1ns / 1ps
// Channel   Role   Beat carries
// in_ch     sink   opcode, weight_in, pose, random_fraction
// out_ch    source picked_index, pose, weight_out
// cfg_ch    sink   particle_count
// Loads and starts are taken while idle; a draw runs multiply, add, then
// read, wait, compare per wheel step, emit; the wait is for the RAM read.
// A two-entry queue lets the front keep accepting while the back walks.
// Reset (rst, synchronous) clears counters, beta, wheel and the queue;
// the particle memories are not cleared. Output stalls hold the back end.
module particle_resampling_wheel_top #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input logic       clk,
  input logic       rst,
  prw_in_if.sink    in_ch,
  prw_out_if.source out_ch,
  prw_cfg_if.sink   cfg_ch
);
  import prw_pkg::*;

  cmd_t                  q_data;
  logic                  q_valid;
  logic                  q_ready;
  logic [CountWidth-1:0] count_reg;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= CountWidth'(1024);
    end else if (cfg_ch.valid) begin
      count_reg <= cfg_ch.data;
    end
  end

  prw_front u_front (
    .clk, .rst, .in_ch, .q_data, .q_valid, .q_ready
  );

  prw_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk, .rst, .q_data, .q_valid, .q_ready, .count_reg, .out_ch
  );
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import prw_pkg::*;

  typedef struct {
    logic [PickWidth-1:0]   idx;
    logic [PoseWidth-1:0]   x;
    logic [PoseWidth-1:0]   y;
    logic [PoseWidth-1:0]   h;
    logic [WeightWidth-1:0] w;
  } pick_t;

  // Mirror of the wheel: particle store, round tracking and the beta walk.
  class wheel_scoreboard;
    logic [WeightWidth-1:0] weight_mem [1024];
    logic [PoseWidth-1:0]   pose_x [1024];
    logic [PoseWidth-1:0]   pose_y [1024];
    logic [PoseWidth-1:0]   pose_h [1024];
    bit                     written [1024];
    int unsigned            load_pos;
    int unsigned            active_n;
    logic [WeightWidth-1:0] top_weight;
    logic [63:0]            beta;
    int unsigned            wheel;
    pick_t                  expected_picks [$];
    int                     errors;
    int                     checked;

    function new();
      load_pos = 0;
      active_n = 1024;
      top_weight = '0;
      beta = '0;
      wheel = 0;
      errors = 0;
      checked = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void set_count(logic [CountWidth-1:0] v);
      if (v == 0) active_n = 1;
      else if (v > 1024) active_n = 1024;
      else active_n = v;
    endfunction

    // A draw only touches entries below the active count.
    function bit drawable();
      for (int i = 0; i < active_n; i++)
        if (!written[i]) return 0;
      return 1;
    endfunction

    function void note_item(opcode_t op, logic [31:0] w, logic [31:0] x,
                            logic [31:0] y, logic [31:0] h, logic [31:0] r);
      int unsigned pos;
      int unsigned idx;
      int unsigned steps;
      pick_t p;
      case (op)
        OP_LOAD: begin
          pos = (load_pos >= active_n) ? 0 : load_pos;
          weight_mem[pos] = w;
          pose_x[pos] = x;
          pose_y[pos] = y;
          pose_h[pos] = h;
          written[pos] = 1;
          if (pos == 0 || w > top_weight) top_weight = w;
          pos++;
          load_pos = (pos >= active_n) ? 0 : pos;
        end
        OP_START: begin
          wheel = int'((64'(r) * 64'(active_n)) >> 32);
          beta = '0;
          load_pos = 0;
        end
        OP_DRAW: begin
          beta = beta + ((64'(r) * 64'(top_weight)) >> 31);
          if (beta > 64'h3_FFFF_FFFF) beta = 64'h3_FFFF_FFFF;
          idx = (wheel >= active_n) ? 0 : wheel;
          steps = 0;
          while (steps < 4 * active_n && beta > 64'(weight_mem[idx])) begin
            beta -= 64'(weight_mem[idx]);
            idx++;
            if (idx >= active_n) idx = 0;
            steps++;
          end
          wheel = idx;
          p.idx = idx[PickWidth-1:0];
          p.x = pose_x[idx];
          p.y = pose_y[idx];
          p.h = pose_h[idx];
          p.w = weight_mem[idx];
          expected_picks = {expected_picks, p};
        end
        default: ;
      endcase
    endfunction

    function void check_pick(pick_t got);
      pick_t e;
      if (expected_picks.size() == 0) begin
        $error("unexpected result beat, picked_index %0d", got.idx);
        errors++;
        return;
      end
      e = expected_picks.pop_front();
      checked++;
      if (got.idx !== e.idx) begin
        $error("picked_index: expected %0d, got %0d", e.idx, got.idx);
        errors++;
      end
      if (got.x !== e.x) begin
        $error("pos_x_out: expected %h, got %h", e.x, got.x);
        errors++;
      end
      if (got.y !== e.y) begin
        $error("pos_y_out: expected %h, got %h", e.y, got.y);
        errors++;
      end
      if (got.h !== e.h) begin
        $error("heading_out: expected %h, got %h", e.h, got.h);
        errors++;
      end
      if (got.w !== e.w) begin
        $error("weight_out: expected %h, got %h", e.w, got.w);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  prw_in_if  in_ch ();
  prw_out_if out_ch ();
  prw_cfg_if cfg_ch ();

  particle_resampling_wheel_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wheel_scoreboard sb;
  bit send_gaps;
  bit recv_gaps;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** particle_resampling_wheel_top: FAILED **");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_NONE;
    in_ch.weight_in = '0;
    in_ch.pos_x_in = '0;
    in_ch.pos_y_in = '0;
    in_ch.heading_in = '0;
    in_ch.random_fraction = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  // Valid stays high after a beat so that a back-to-back item follows
  // without a gap; the callers drop it before they wait.
  task automatic send_item(opcode_t op, logic [31:0] w, logic [31:0] x,
                           logic [31:0] y, logic [31:0] h, logic [31:0] r);
    int gap;
    gap = send_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.weight_in <= w;
    in_ch.pos_x_in <= x;
    in_ch.pos_y_in <= y;
    in_ch.heading_in <= h;
    in_ch.random_fraction <= r;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(op, w, x, y, h, r);
    items_sent++;
    if ($urandom_range(0, 49) == 0) send_gaps = ~send_gaps;
  endtask

  task automatic load_random(int style);
    logic [31:0] w;
    case (style)
      0: w = '0;
      1: w = $urandom;
      2: w = $urandom_range(32'h0100_0000, 32'h0200_0000);
      3: w = 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: w = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4095);
    endcase
    send_item(OP_LOAD, w, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Registers change only with nothing in flight; loads and starts may
  // still sit in the queue, so allow the back end time to drain.
  task automatic write_count(logic [CountWidth-1:0] v);
    in_ch.valid <= 1'b0;
    while (sb.expected_picks.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_count(v);
  endtask

  task automatic run_round(logic [CountWidth-1:0] v, int draws, int style, bit full_load);
    int k;
    write_count(v);
    send_item(OP_START, '0, '0, '0, '0, $urandom);
    if (full_load || !sb.drawable())
      for (k = 0; k < sb.active_n; k++) load_random(style);
    send_item(OP_START, '0, '0, '0, '0, $urandom);
    for (k = 0; k < draws; k++) begin
      case ($urandom_range(0, 19))
        0: send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: send_item(OP_START, '0, '0, '0, '0, $urandom);
        2: load_random(style);
        default: begin
          if (sb.drawable()) send_item(OP_DRAW, '0, '0, '0, '0, $urandom);
          else load_random(style);
        end
      endcase
    end
  endtask

  // Result side: random stalls per beat, plus one long hold-off that lets
  // the block fill up while the sender keeps offering items.
  initial begin
    bit held;
    int stall;
    pick_t got;
    held = 0;
    stall = 0;
    recv_gaps = 1;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sb.checked == 30) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
        if (out_ch.valid && out_ch.ready) begin
          got.idx = out_ch.picked_index;
          got.x = out_ch.pos_x_out;
          got.y = out_ch.pos_y_out;
          got.h = out_ch.heading_out;
          got.w = out_ch.weight_out;
          sb.check_pick(got);
          if ($urandom_range(0, 39) == 0) recv_gaps = ~recv_gaps;
          stall = recv_gaps ? $urandom_range(0, 18) : 0;
        end
      end
    end
  end

  initial begin
    int limit;
    sb = new();
    send_gaps = 0;
    items_sent = 0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two particles at the field extremes, with the wheel placed at the
    // last index and random fractions at both ends.
    write_count(11'd2);
    send_item(OP_LOAD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, '0);
    send_item(OP_LOAD, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, '0);
    send_item(OP_START, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'h0000_0000);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_NONE, 32'hFFFF_FFFF, '1, '1, '1, '1);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'h8000_0000);
    // All weights zero: beta never moves and the wheel stays put.
    write_count(11'd3);
    send_item(OP_LOAD, '0, 32'h0001_0000, 32'hFFFF_0000, 32'h0003_243F, '0);
    send_item(OP_LOAD, '0, 32'h0002_0000, 32'hFFFE_0000, 32'hFFFC_DBC1, '0);
    send_item(OP_LOAD, '0, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_0000, '0);
    send_item(OP_START, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'h0000_0000);
    // Shrinking the count leaves the wheel past the end; the walk restarts at 0.
    write_count(11'd2);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'h4000_0000);
    // Single particle, and the clamped count values.
    write_count(11'd0);
    send_item(OP_START, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'hFFFF_FFFF);
    write_count(11'd1);
    send_item(OP_LOAD, 32'hFFFF_FFFF, '1, '1, '1, '0);
    send_item(OP_START, '0, '0, '0, '0, '0);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_DRAW, '0, '0, '0, '0, 32'hFFFF_FFFF);

    // Full-size round once, then the over-range count on the same store.
    run_round(11'd1024, 10, 2, 1);
    run_round(11'd2047, 6, 2, 0);

    send_gaps = 1;
    limit = items_sent + 500;
    while (items_sent < limit) begin
      case ($urandom_range(0, 9))
        0: run_round(11'($urandom_range(0, 1)), $urandom_range(3, 15),
                     $urandom_range(0, 4), 1);
        1: run_round(11'($urandom_range(17, 40)), $urandom_range(5, 20),
                     $urandom_range(1, 4), 1);
        default: run_round(11'($urandom_range(2, 16)), $urandom_range(5, 25),
                           $urandom_range(0, 4), $urandom_range(0, 3) != 0);
      endcase
    end

    in_ch.valid <= 1'b0;
    while (sb.expected_picks.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_picks.size() == 0)
      $display("** particle_resampling_wheel_top: PASSED **");
    else
      $display("** particle_resampling_wheel_top: FAILED **");
    $finish;
  end
endmodule
